/* sv/stid_pkg.sv */
// Shared types and constants for the sorted table insert/delete block.
// Used by the channel interfaces, the table cell and the top level.
// Depends on nothing.

package stid_pkg;

  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;

  // Operation codes carried in the mode field of an input item.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Status codes returned with every result item.
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef logic signed [VAL_W-1:0] stid_val_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } stid_state_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic      load;    // capture compare flags against key
    logic      is_del;  // operation is a delete
    logic      ins_go;  // commit an insert this cycle
    logic      del_go;  // commit a delete this cycle
    stid_val_t key;     // value being inserted or deleted
  } stid_cmd_t;

endpackage

/* sv/stid_if.sv */
// Valid/ready channel interfaces for the sorted table block.
// stid_in_if carries operation items, stid_out_if carries result items.
// Depends on stid_pkg.

interface stid_in_if import stid_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      mode;
  stid_val_t item_value;

  modport source (output valid, output mode, output item_value, input ready);
  modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface stid_out_if import stid_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ECOUNT_W-1:0] entry_count;
  stid_val_t           smallest_value;

  modport source (output valid, output status, output entry_count, output smallest_value,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input smallest_value,
                  output ready);
endinterface

/* sv/stid_cell.sv */
// One slot of the sorted table: holds a value and its compare flags.
// Trades values with its left and right neighbors on insert and delete.
// Depends on stid_pkg.

module stid_cell import stid_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic          clk,
  input  stid_cmd_t     cmd,
  input  logic [CW-1:0] count,
  input  stid_val_t     left_val,
  input  logic          left_mv,
  input  stid_val_t     right_val,
  output stid_val_t     val_q,
  output stid_val_t     val_nxt,
  output logic          mv_q,
  output logic          hit_q
);

  stid_val_t val_r;
  logic      mv_r, mv_nxt;
  logic      hit_r, hit_nxt;
  logic      occ, at_cnt;

  assign occ    = CW'(INDEX) < count;
  assign at_cnt = CW'(INDEX) == count;

  // The move flag marks entries that lie past the operation point: greater than
  // the key for an insert, greater or equal for a delete.
  always_comb begin
    mv_nxt  = mv_r;
    hit_nxt = hit_r;
    if (cmd.load) begin
      mv_nxt  = occ && (cmd.is_del ? (val_r >= cmd.key) : (val_r > cmd.key));
      hit_nxt = occ && (val_r == cmd.key);
    end
  end

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins_go) begin
      if (left_mv) begin
        val_nxt = left_val;
      end else if (mv_r || at_cnt) begin
        val_nxt = cmd.key;
      end
    end else if (cmd.del_go && mv_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    mv_r  <= mv_nxt;
    hit_r <= hit_nxt;
  end

  assign val_q = val_r;
  assign mv_q  = mv_r;
  assign hit_q = hit_r;

endmodule

/* sv/sorted_table_insert_delete.sv */
// Top level of the sorted table: controller, count register and cell chain.
// Depends on stid_pkg, stid_in_if / stid_out_if and stid_cell.
//
//   channel  direction  handshake               item contents
//   in_ch    in         valid/ready (sink)      mode, item_value
//   out_ch   out        valid/ready (source)    status, entry_count, smallest_value
//
// For each item, the accepting edge registers each cell's compare flags, and
// the shift step in ST_APPLY, once the output register is free, shifts the
// chain and loads the result; the flag register lies between the two.
// Reset clears the entry count and the handshake state; stored values need
// no clearing, so there is no start-up pass and the first item is taken at once.
// A result that is not taken holds the shift step until the output register
// frees up; the next item is still accepted while a result waits.

module sorted_table_insert_delete import stid_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst_n,
  stid_in_if.sink    in_ch,
  stid_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  stid_state_t state_r, state_nxt;
  logic        op_r;
  stid_val_t   key_r;
  logic [CW-1:0] count_r, count_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [ECOUNT_W-1:0] ecount_r;
  stid_val_t           smallest_r;

  logic      in_fire, out_free, apply_fire;
  logic      full, found, is_del;
  stid_cmd_t cmd;

  stid_val_t             cell_val [CAPACITY];
  stid_val_t             cell_nxt [CAPACITY];
  logic [CAPACITY-1:0]   cell_mv;
  logic [CAPACITY-1:0]   cell_hit;
  logic [CW+ECOUNT_W-1:0] count_ext;

  // Handshake and step control.
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    apply_fire  = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_APPLY: apply_fire  = out_free;
      default: begin
        in_ch.ready = 1'b0;
        apply_fire  = 1'b0;
      end
    endcase
  end

  // The table is full when every cell holds a value; a delete finds its value
  // when any occupied cell matched the key at compare time.
  assign full   = count_r == CW'(CAPACITY);
  assign found  = |cell_hit;
  assign is_del = op_r == MODE_DELETE;

  always_comb begin
    cmd.load   = in_fire;
    cmd.is_del = (state_r == ST_IDLE) ? (in_ch.mode == MODE_DELETE) : is_del;
    cmd.ins_go = apply_fire && !is_del && !full;
    cmd.del_go = apply_fire && is_del && found;
    cmd.key    = (state_r == ST_IDLE) ? in_ch.item_value : key_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_go) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.del_go) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    if (is_del) begin
      status_nxt = found ? STAT_DONE : STAT_NOT_FOUND;
    end else begin
      status_nxt = full ? STAT_FULL : STAT_DONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // The entry count field keeps the low bits of the stored count.
  assign count_ext = {{ECOUNT_W{1'b0}}, count_nxt};

  // Cell chain. The first cell sees no left neighbor and the last cell keeps
  // its own value when its right neighbor would be read.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    stid_val_t lv, rv;
    logic      lmv;
    if (i == 0) begin : g_first
      assign lv  = cell_val[i];
      assign lmv = 1'b0;
    end else begin : g_mid
      assign lv  = cell_val[i-1];
      assign lmv = cell_mv[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = cell_val[i];
    end else begin : g_inner
      assign rv = cell_val[i+1];
    end

    stid_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .left_val  (lv),
      .left_mv   (lmv),
      .right_val (rv),
      .val_q     (cell_val[i]),
      .val_nxt   (cell_nxt[i]),
      .mv_q      (cell_mv[i]),
      .hit_q     (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.mode;
      key_r <= in_ch.item_value;
    end
    if (apply_fire) begin
      status_r   <= status_nxt;
      ecount_r   <= count_ext[ECOUNT_W-1:0];
      smallest_r <= (count_nxt == '0) ? stid_val_t'(0) : cell_nxt[0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.entry_count    = ecount_r;
  assign out_ch.smallest_value = smallest_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    !apply_fire |=> $stable(count_r))
    else $error("entry count changed outside the shift step");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_fire && !is_del && full) |=> (count_r == $past(count_r)))
    else $error("refused insert changed the entry count");

  a_delete_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    (apply_fire && is_del && found) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("successful delete did not remove one entry");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    apply_fire |=> (out_valid_r && state_r == ST_IDLE))
    else $error("shift step did not load a result");
`endif

endmodule

/* dv/tb_sorted_table_insert_delete.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_insert_delete: directed table, then random ops.
// Depends on stid_pkg, stid_in_if / stid_out_if and the sorted_table_insert_delete RTL.

module tb_sorted_table_insert_delete;
  import stid_pkg::*;

  localparam int TABLE_DEPTH     = 16;
  localparam int RANDOM_OPS      = 1400;
  localparam int BIAS_SEGMENT    = 60;    // items between changes of the insert/delete mix
  localparam int RECENT_KEEP     = 24;    // inserted values remembered for later deletes
  localparam int HOLD_AFTER      = 400;   // accepted items before the long receiver hold-off
  localparam int LONG_HOLD       = 250;   // cycles the receiver refuses results in that hold-off
  localparam int DRAIN_CYCLES    = 10;    // extra wait after the last expected result has been checked
  localparam int WATCHDOG_CYCLES = 3000;  // cycles without any handshake before giving up
  localparam int MAX_REPORTS     = 50;

  // One result item as the block reports it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ECOUNT_W-1:0] entry_count;
    stid_val_t           smallest_value;
  } table_result_t;

  // One row of the directed stimulus. Rows with a hand-written result carry it in want;
  // all other rows are checked against the shadow table.
  typedef struct {
    logic          mode;
    stid_val_t     item_value;
    bit            has_want;
    table_result_t want;
  } table_op_row_t;

  logic clk;
  logic rst_n;

  stid_in_if  in_ch ();
  stid_out_if out_ch ();

  sorted_table_insert_delete #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the table: the first shadow_count entries are valid, kept ascending.
  stid_val_t     shadow_entries [TABLE_DEPTH];
  int            shadow_count;

  table_op_row_t directed_ops [$];
  table_result_t pending_results [$];
  stid_val_t     recent_values [$];

  int n_in_accepted;
  int error_count;
  int idle_cycles;
  int burst_left;
  bit long_hold_done;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Applies one operation to the shadow table and returns the result the block must give.
  // An insert goes after every stored value less than or equal to it, so equal values keep
  // their arrival order. A delete removes the first copy counted from the smallest entry.
  function automatic table_result_t apply_table_op(input logic mode, input stid_val_t value);
    table_result_t res;
    int pos;
    int i;
    pos = 0;
    if (mode == MODE_INSERT) begin
      if (shadow_count >= TABLE_DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        while (pos < shadow_count && shadow_entries[pos] <= value) pos++;
        for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[pos] = value;
        shadow_count++;
        res.status = STAT_DONE;
      end
    end else begin
      while (pos < shadow_count && shadow_entries[pos] != value) pos++;
      if (pos >= shadow_count) begin
        res.status = STAT_NOT_FOUND;
      end else begin
        for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
        shadow_count--;
        res.status = STAT_DONE;
      end
    end
    res.entry_count    = shadow_count[ECOUNT_W-1:0];
    res.smallest_value = (shadow_count > 0) ? shadow_entries[0] : '0;
    return res;
  endfunction

  // Values that sit on the edges of the signed range or have striped bit patterns.
  function automatic stid_val_t corner_value(input int idx);
    case (idx)
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4:       return 32'sd1;
      5:       return 32'sh5555_5555;
      6:       return 32'shAAAA_AAAA;
      default: return 32'sd100;
    endcase
  endfunction

  task automatic add_row(input logic mode, input stid_val_t value, input bit has_want,
                         input logic [STATUS_W-1:0] status, input int count,
                         input stid_val_t smallest);
    table_op_row_t row;
    row.mode                = mode;
    row.item_value          = value;
    row.has_want            = has_want;
    row.want.status         = status;
    row.want.entry_count    = count[ECOUNT_W-1:0];
    row.want.smallest_value = smallest;
    directed_ops.push_back(row);
  endtask

  // Directed part: empty-table delete, the extremes of the value range, equal values,
  // a miss, filling the table to capacity and an insert into the full table.
  task automatic build_directed_ops();
    int i;
    add_row(MODE_DELETE, 32'sd5,          1'b1, STAT_NOT_FOUND, 0, 32'sd0);
    add_row(MODE_INSERT, 32'sh7FFF_FFFF,  1'b1, STAT_DONE,      1, 32'sh7FFF_FFFF);
    add_row(MODE_INSERT, 32'sh8000_0000,  1'b1, STAT_DONE,      2, 32'sh8000_0000);
    add_row(MODE_INSERT, 32'sd0,          1'b1, STAT_DONE,      3, 32'sh8000_0000);
    add_row(MODE_INSERT, -32'sd1,         1'b0, STAT_DONE,      0, 32'sd0);
    add_row(MODE_INSERT, 32'sd0,          1'b0, STAT_DONE,      0, 32'sd0);
    add_row(MODE_DELETE, 32'sd0,          1'b0, STAT_DONE,      0, 32'sd0);
    add_row(MODE_DELETE, 32'sd12345,      1'b0, STAT_DONE,      0, 32'sd0);
    add_row(MODE_DELETE, 32'sh8000_0000,  1'b0, STAT_DONE,      0, 32'sd0);
    // Three entries are left; thirteen more fill the table, the most negative value first.
    add_row(MODE_INSERT, 32'sh8000_0000,  1'b0, STAT_DONE,      0, 32'sd0);
    for (i = 1; i < 13; i++) begin
      add_row(MODE_INSERT, 32'sd1000 * i - 32'sd5000, 1'b0, STAT_DONE, 0, 32'sd0);
    end
    add_row(MODE_INSERT, 32'sd77,         1'b1, STAT_FULL, TABLE_DEPTH, 32'sh8000_0000);
    add_row(MODE_DELETE, 32'sh7FFF_FFFF,  1'b0, STAT_DONE,      0, 32'sd0);
  endtask

  // Random operation with an insert share of ins_pct percent. Deletes mostly aim at values
  // inserted lately, so that they hit; the rest miss or hit by chance.
  task automatic pick_random_op(input int ins_pct, output logic mode, output stid_val_t value);
    int r;
    mode = ($urandom_range(99, 0) < ins_pct) ? MODE_INSERT : MODE_DELETE;
    r = $urandom_range(99, 0);
    if (mode == MODE_INSERT) begin
      if (r < 35) begin
        value = corner_value($urandom_range(7, 0));
      end else if (r < 55 && recent_values.size() > 0) begin
        value = recent_values[$urandom_range(recent_values.size() - 1, 0)];
      end else begin
        value = $urandom;
      end
      recent_values.push_back(value);
      if (recent_values.size() > RECENT_KEEP) void'(recent_values.pop_front());
    end else begin
      if (r < 70 && recent_values.size() > 0) begin
        value = recent_values[$urandom_range(recent_values.size() - 1, 0)];
      end else if (r < 85) begin
        value = corner_value($urandom_range(7, 0));
      end else begin
        value = $urandom;
      end
    end
  endtask

  // The sender works in bursts. Between most bursts valid drops for a few cycles; some
  // bursts follow straight on, which gives long stretches without any idle cycle.
  task automatic pause_between_bursts();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      if ($urandom_range(4, 0) != 0) begin
        gap = $urandom_range(6, 1);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Presents one item at the falling edge and holds it until the block takes it.
  // Valid stays high afterwards; only a gap lowers it.
  task automatic offer_item(input logic mode, input stid_val_t value);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.item_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // Stimulus: reset, the directed table, then random items in segments whose insert share
  // changes, so the table keeps wandering between empty and full.
  initial begin : sender
    int            k;
    int            ins_pct;
    logic          mode;
    stid_val_t     value;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_INSERT;
    in_ch.item_value = '0;
    shadow_count     = 0;
    n_in_accepted    = 0;
    error_count      = 0;
    idle_cycles      = 0;
    burst_left       = 0;
    ins_pct          = 50;
    build_directed_ops();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) begin
      pause_between_bursts();
      offer_item(directed_ops[i].mode, directed_ops[i].item_value);
    end

    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % BIAS_SEGMENT == 0) begin
        case ($urandom_range(3, 0))
          0:       ins_pct = 25;
          1:       ins_pct = 50;
          2:       ins_pct = 75;
          default: ins_pct = 90;
        endcase
      end
      pick_random_op(ins_pct, mode, value);
      pause_between_bursts();
      offer_item(mode, value);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    // The watchdog bounds this wait if a result never shows up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // The receiver cycles through segments of always ready, coin-flip ready and mostly
  // stalled. Once, after enough items, it refuses results for a long stretch while the
  // sender keeps offering, so the block fills its output and stalls its input.
  initial begin : receiver
    int seg_len;
    int style;
    out_ch.ready   = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!long_hold_done && n_in_accepted >= HOLD_AFTER) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        seg_len = $urandom_range(80, 20);
        style   = $urandom_range(2, 0);
        repeat (seg_len) begin
          @(negedge clk);
          case (style)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(1, 0) == 1);
            default: out_ch.ready <= ($urandom_range(3, 0) == 0);
          endcase
        end
      end
    end
  end

  // Both channels are sampled at the rising edge. An accepted input item runs through the
  // shadow table and its expected result joins the queue; an accepted result is compared
  // with the oldest expectation. Rows of the directed table with a hand-written result
  // use that result instead of the shadow table's.
  always @(posedge clk) begin : monitor
    table_result_t want;
    table_result_t got;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        want  = apply_table_op(in_ch.mode, in_ch.item_value);
        if (n_in_accepted < directed_ops.size() && directed_ops[n_in_accepted].has_want) begin
          want = directed_ops[n_in_accepted].want;
        end
        pending_results.push_back(want);
        n_in_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved              = 1'b1;
        got.status         = out_ch.status;
        got.entry_count    = out_ch.entry_count;
        got.smallest_value = out_ch.smallest_value;
        if (pending_results.size() == 0) begin
          note_error($sformatf("result with nothing expected: status %0d count %0d smallest %0d",
                               got.status, got.entry_count, got.smallest_value));
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            note_error($sformatf("status: expected %0d, actual %0d",
                                 want.status, got.status));
          end
          if (got.entry_count !== want.entry_count) begin
            note_error($sformatf("entry_count: expected %0d, actual %0d",
                                 want.entry_count, got.entry_count));
          end
          if (got.smallest_value !== want.smallest_value) begin
            note_error($sformatf("smallest_value: expected %0d, actual %0d",
                                 want.smallest_value, got.smallest_value));
          end
        end
      end
      // Watchdog: a long run of cycles with no handshake on either side means a hang.
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
          $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_CYCLES);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

endmodule
